>>> rtl/core/svm_pkg.sv
// package: constants, types and helpers of the sample voice mixer
`timescale 1ns / 1ps
package svm_pkg;

  localparam int SAMPLE_WORDS = 65536;
  localparam int MAX_VOICES   = 16;
  localparam int NUM_SLOTS    = 16;
  localparam int NUM_NOTES    = 128;

  localparam int ADDR_W  = $clog2(SAMPLE_WORDS);
  localparam int VIDX_W  = $clog2(MAX_VOICES);
  localparam int VCNT_W  = $clog2(MAX_VOICES + 1);
  localparam int SLOT_W  = $clog2(NUM_SLOTS);
  localparam int LEN_W   = 17;
  localparam int ACC_W   = 30;
  localparam int AUDIO_W = 24;
  localparam int QDEPTH  = 2;

  typedef enum logic [2:0] {
    CMD_WRITE  = 3'd0,
    CMD_DEFINE = 3'd1,
    CMD_MAP    = 3'd2,
    CMD_ON     = 3'd3,
    CMD_OFF    = 3'd4,
    CMD_MIX    = 3'd5,
    CMD_NOP6   = 3'd6,
    CMD_NOP7   = 3'd7
  } command_t;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_DROPPED = 2'd1,
    STAT_IGNORED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAP,
    S_NOTE,
    S_OFF_SCAN,
    S_OFF_END,
    S_MIX_RD,
    S_MIX_ACC,
    S_FINISH
  } engine_state_t;

  typedef struct packed {
    command_t            op;
    logic [6:0]          note;
    logic [3:0]          slot;
    logic                map_valid;
    logic [15:0]         address;
    logic [16:0]         length;
    logic signed [15:0]  sample_value;
    logic signed [23:0]  left_in;
    logic signed [23:0]  right_in;
  } req_t;

  function automatic logic signed [AUDIO_W-1:0] sat24(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    begin
      hi = ACC_W'(8388607);
      lo = -ACC_W'(8388608);
      if (v > hi) sat24 = 24'sh7FFFFF;
      else if (v < lo) sat24 = 24'sh800000;
      else sat24 = v[AUDIO_W-1:0];
    end
  endfunction

endpackage

>>> rtl/core/svm_ifs.sv
// request and result channel interfaces
`timescale 1ns / 1ps
interface svm_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic [6:0]         note;
  logic [3:0]         slot;
  logic               map_valid;
  logic [15:0]        address;
  logic [16:0]        length;
  logic signed [15:0] sample_value;
  logic signed [23:0] left_in;
  logic signed [23:0] right_in;
  modport source (output valid, command, note, slot, map_valid, address, length,
                  sample_value, left_in, right_in, input ready);
  modport sink (input valid, command, note, slot, map_valid, address, length,
                sample_value, left_in, right_in, output ready);
endinterface

interface svm_res_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] left_out;
  logic signed [23:0] right_out;
  logic [1:0]         status;
  logic [4:0]         active_voices;
  modport source (output valid, left_out, right_out, status, active_voices, input ready);
  modport sink (input valid, left_out, right_out, status, active_voices, output ready);
endinterface

>>> rtl/core/polyphonic_sample_voice_mixer.sv
// top level: polyphonic sample playback voice mixer
// load commands go straight to S_FINISH; note on passes S_MAP and S_NOTE, note off also
// scans every voice; mix visits each voice and reads sample memory once per playing voice
// the engine takes a request only when idle; the two-entry queue takes new ones meanwhile
// reset: synchronous; clears voices, note map, slot table, start counter and result valid
// sample memory holds no reset value and needs none until written
`timescale 1ns / 1ps
module polyphonic_sample_voice_mixer (
  input logic       clk,
  input logic       rst,
  svm_req_if.sink   req,
  svm_res_if.source res
);

  svm_pkg::req_t q_data;
  logic q_valid;
  logic q_ready;

  svm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .q_data  (q_data),
    .q_valid (q_valid),
    .q_ready (q_ready)
  );

  svm_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .in_data  (q_data),
    .in_valid (q_valid),
    .in_ready (q_ready),
    .res      (res)
  );

endmodule

>>> rtl/core/svm_front.sv
// front end: accepts requests, decodes the command and queues them
`timescale 1ns / 1ps
module svm_front (
  input  logic          clk,
  input  logic          rst,
  svm_req_if.sink       req,
  output svm_pkg::req_t q_data,
  output logic          q_valid,
  input  logic          q_ready
);

  svm_pkg::req_t q [svm_pkg::QDEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  svm_pkg::req_t dec;

  always_comb begin
    dec.op           = svm_pkg::command_t'(req.command);
    dec.note         = req.note;
    dec.slot         = req.slot;
    dec.map_valid    = req.map_valid;
    dec.address      = req.address;
    dec.length       = req.length;
    dec.sample_value = req.sample_value;
    dec.left_in      = req.left_in;
    dec.right_in     = req.right_in;
  end

  assign req.ready = (count != 2'(svm_pkg::QDEPTH));
  assign push      = req.valid && req.ready;
  assign q_valid   = (count != 2'd0);
  assign pop       = q_valid && q_ready;
  assign q_data    = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= dec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

>>> rtl/core/svm_engine.sv
// back end: tables, voices, sample memory and the mix sequencer
`timescale 1ns / 1ps
module svm_engine (
  input  logic          clk,
  input  logic          rst,
  input  svm_pkg::req_t in_data,
  input  logic          in_valid,
  output logic          in_ready,
  svm_res_if.source     res
);

  svm_pkg::engine_state_t state, state_next;

  logic signed [15:0] mem [svm_pkg::SAMPLE_WORDS];
  logic signed [15:0] mem_rdata;
  logic [svm_pkg::ADDR_W-1:0] mem_raddr;
  logic mem_we;

  logic [15:0] slot_start  [svm_pkg::NUM_SLOTS];
  logic [svm_pkg::LEN_W-1:0] slot_length [svm_pkg::NUM_SLOTS];
  logic [svm_pkg::NUM_NOTES-1:0] map_ok;
  logic [svm_pkg::SLOT_W-1:0] map_slot [svm_pkg::NUM_NOTES];
  logic [svm_pkg::SLOT_W-1:0] map_slot_r;
  logic map_ok_r;

  logic [svm_pkg::MAX_VOICES-1:0] voice_active;
  logic [svm_pkg::SLOT_W-1:0] voice_slot [svm_pkg::MAX_VOICES];
  logic [svm_pkg::LEN_W-1:0] voice_position [svm_pkg::MAX_VOICES];
  logic [31:0] voice_stamp [svm_pkg::MAX_VOICES];
  logic [31:0] start_counter;

  svm_pkg::req_t cur;
  svm_pkg::status_t stat;
  logic [svm_pkg::VCNT_W-1:0] vcnt;
  logic signed [svm_pkg::ACC_W-1:0] acc_l;
  logic signed [svm_pkg::ACC_W-1:0] acc_r;
  logic best_found;
  logic [svm_pkg::VIDX_W-1:0] best_idx;
  logic [31:0] best_age;

  logic res_valid;
  logic signed [23:0] res_left;
  logic signed [23:0] res_right;
  logic [1:0] res_status;
  logic [4:0] res_active;

  logic take;
  logic res_free;
  logic [svm_pkg::VIDX_W-1:0] vi;
  logic last_voice;
  logic [svm_pkg::SLOT_W-1:0] v_slot;
  logic [svm_pkg::LEN_W-1:0] v_len;
  logic [svm_pkg::LEN_W-1:0] v_pos;
  logic [svm_pkg::LEN_W-1:0] v_pos_inc;
  logic v_act;
  logic v_play;
  logic [31:0] v_age;
  logic free_found;
  logic [svm_pkg::VIDX_W-1:0] free_idx;
  logic signed [svm_pkg::ACC_W-1:0] word_ext;

  assign in_ready   = (state == svm_pkg::S_IDLE);
  assign take       = in_ready && in_valid;
  assign res_free   = !res_valid || res.ready;
  assign vi         = vcnt[svm_pkg::VIDX_W-1:0];
  assign last_voice = (vi == svm_pkg::VIDX_W'(svm_pkg::MAX_VOICES - 1));
  assign v_slot     = voice_slot[vi];
  assign v_len      = slot_length[v_slot];
  assign v_pos      = voice_position[vi];
  assign v_pos_inc  = v_pos + 1'b1;
  assign v_act      = voice_active[vi];
  assign v_play     = v_act && (v_pos < v_len);
  assign v_age      = start_counter - voice_stamp[vi];
  assign mem_raddr  = slot_start[v_slot] + v_pos[svm_pkg::ADDR_W-1:0];
  assign mem_we     = take && (in_data.op == svm_pkg::CMD_WRITE);
  assign word_ext   = {{(svm_pkg::ACC_W - 24){mem_rdata[15]}}, mem_rdata, 8'b0};

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = svm_pkg::MAX_VOICES - 1; i >= 0; i--) begin
      if (!voice_active[i]) begin
        free_found = 1'b1;
        free_idx   = svm_pkg::VIDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[in_data.address] <= in_data.sample_value;
    mem_rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    map_slot_r <= map_slot[cur.note];
    map_ok_r   <= map_ok[cur.note];
    if (take && in_data.op == svm_pkg::CMD_MAP && in_data.map_valid) begin
      map_slot[in_data.note] <= in_data.slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= svm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      svm_pkg::S_IDLE: begin
        if (take) begin
          case (in_data.op)
            svm_pkg::CMD_ON, svm_pkg::CMD_OFF: state_next = svm_pkg::S_MAP;
            svm_pkg::CMD_MIX: state_next = svm_pkg::S_MIX_RD;
            default: state_next = svm_pkg::S_FINISH;
          endcase
        end
      end
      svm_pkg::S_MAP: state_next = svm_pkg::S_NOTE;
      svm_pkg::S_NOTE: begin
        if (cur.op == svm_pkg::CMD_OFF && map_ok_r) state_next = svm_pkg::S_OFF_SCAN;
        else state_next = svm_pkg::S_FINISH;
      end
      svm_pkg::S_OFF_SCAN: if (last_voice) state_next = svm_pkg::S_OFF_END;
      svm_pkg::S_OFF_END: state_next = svm_pkg::S_FINISH;
      svm_pkg::S_MIX_RD: begin
        if (v_play) state_next = svm_pkg::S_MIX_ACC;
        else if (last_voice) state_next = svm_pkg::S_FINISH;
      end
      svm_pkg::S_MIX_ACC: begin
        if (last_voice) state_next = svm_pkg::S_FINISH;
        else state_next = svm_pkg::S_MIX_RD;
      end
      svm_pkg::S_FINISH: if (res_free) state_next = svm_pkg::S_IDLE;
      default: state_next = svm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      svm_pkg::S_IDLE: begin
        if (take) begin
          cur   <= in_data;
          stat  <= svm_pkg::STAT_DONE;
          vcnt  <= '0;
          acc_l <= {{(svm_pkg::ACC_W - 24){in_data.left_in[23]}}, in_data.left_in};
          acc_r <= {{(svm_pkg::ACC_W - 24){in_data.right_in[23]}}, in_data.right_in};
          best_found <= 1'b0;
        end
      end
      svm_pkg::S_NOTE: begin
        if (cur.op == svm_pkg::CMD_ON) begin
          if (!map_ok_r || slot_length[map_slot_r] == '0) begin
            stat <= svm_pkg::STAT_IGNORED;
          end else if (!free_found) begin
            stat <= svm_pkg::STAT_DROPPED;
          end else begin
            voice_slot[free_idx]     <= map_slot_r;
            voice_position[free_idx] <= '0;
            voice_stamp[free_idx]    <= start_counter;
          end
        end else if (!map_ok_r) begin
          stat <= svm_pkg::STAT_IGNORED;
        end
      end
      svm_pkg::S_OFF_SCAN: begin
        if (v_act && v_slot == map_slot_r && (!best_found || v_age < best_age)) begin
          best_found <= 1'b1;
          best_idx   <= vi;
          best_age   <= v_age;
        end
        vcnt <= vcnt + 1'b1;
      end
      svm_pkg::S_OFF_END: if (!best_found) stat <= svm_pkg::STAT_IGNORED;
      svm_pkg::S_MIX_RD: begin
        if (v_play) voice_position[vi] <= v_pos_inc;
        else if (!last_voice) vcnt <= vcnt + 1'b1;
      end
      svm_pkg::S_MIX_ACC: begin
        acc_l <= acc_l + word_ext;
        acc_r <= acc_r + word_ext;
        if (!last_voice) vcnt <= vcnt + 1'b1;
      end
      default: ;
    endcase
  end

  // control state: note map valid bits, voice activity, counter
  always_ff @(posedge clk) begin
    if (rst) begin
      map_ok        <= '0;
      voice_active  <= '0;
      start_counter <= '0;
    end else begin
      case (state)
        svm_pkg::S_IDLE: begin
          if (take && in_data.op == svm_pkg::CMD_MAP) map_ok[in_data.note] <= in_data.map_valid;
        end
        svm_pkg::S_NOTE: begin
          if (cur.op == svm_pkg::CMD_ON && map_ok_r && slot_length[map_slot_r] != '0
              && free_found) begin
            voice_active[free_idx] <= 1'b1;
            start_counter          <= start_counter + 1'b1;
          end
        end
        svm_pkg::S_OFF_END: if (best_found) voice_active[best_idx] <= 1'b0;
        svm_pkg::S_MIX_RD: begin
          if (v_act && (!v_play || v_pos_inc >= v_len)) voice_active[vi] <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // slot table: cleared at reset, written by define
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < svm_pkg::NUM_SLOTS; i++) begin
        slot_length[i] <= '0;
        slot_start[i]  <= '0;
      end
    end else if (take && in_data.op == svm_pkg::CMD_DEFINE) begin
      slot_start[in_data.slot]  <= in_data.address;
      slot_length[in_data.slot] <= in_data.length[16] ? 17'h10000 : in_data.length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == svm_pkg::S_FINISH && res_free) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == svm_pkg::S_FINISH && res_free) begin
      res_left   <= (cur.op == svm_pkg::CMD_MIX) ? svm_pkg::sat24(acc_l) : '0;
      res_right  <= (cur.op == svm_pkg::CMD_MIX) ? svm_pkg::sat24(acc_r) : '0;
      res_status <= stat;
      res_active <= 5'($countones(voice_active));
    end
  end

  assign res.valid         = res_valid;
  assign res.left_out      = res_left;
  assign res.right_out     = res_right;
  assign res.status        = res_status;
  assign res.active_voices = res_active;

endmodule

>>> rtl/core/svm_checker.sv
// port checker for the voice mixer and its bind
`timescale 1ns / 1ps
module svm_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [23:0] left_out,
  input logic [23:0] right_out,
  input logic [1:0]  status,
  input logic [4:0]  active_voices
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(left_out) && $stable(status))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  a_status: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> status <= svm_pkg::STAT_IGNORED)
    else $error("bad status code");

  a_quiet: assert property (@(posedge clk) disable iff (rst)
    res_valid && status != svm_pkg::STAT_DONE |-> left_out == 24'd0 && right_out == 24'd0)
    else $error("audio on a note result");

  a_count: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> active_voices <= 5'd16)
    else $error("too many active voices");

endmodule

bind polyphonic_sample_voice_mixer svm_checker u_svm_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .left_out      (res.left_out),
  .right_out     (res.right_out),
  .status        (res.status),
  .active_voices (res.active_voices)
);

>>> dv/tb_top.sv
// testbench for the sample voice mixer: directed table, then random requests, predictor check
`timescale 1ns / 1ps
module tb_top;

  typedef struct {
    logic signed [23:0] left;
    logic signed [23:0] right;
    svm_pkg::status_t   status;
    logic [4:0]         voices;
  } mix_result_t;

  typedef struct {
    svm_pkg::req_t cmd;
    int            reps;
    bit            typed;
    mix_result_t   want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  svm_req_if req_if ();
  svm_res_if res_if ();

  polyphonic_sample_voice_mixer DUT (.clk(clk), .rst(rst), .req(req_if), .res(res_if));

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic signed [15:0] sample_mem [svm_pkg::SAMPLE_WORDS];
  bit                 word_written [svm_pkg::SAMPLE_WORDS];
  logic [15:0]        slot_base [svm_pkg::NUM_SLOTS];
  logic [16:0]        slot_len [svm_pkg::NUM_SLOTS];
  bit                 note_mapped [svm_pkg::NUM_NOTES];
  logic [3:0]         note_slot [svm_pkg::NUM_NOTES];
  bit                 voice_on [svm_pkg::MAX_VOICES];
  logic [3:0]         voice_slot [svm_pkg::MAX_VOICES];
  logic [16:0]        voice_pos [svm_pkg::MAX_VOICES];
  logic [31:0]        voice_stamp [svm_pkg::MAX_VOICES];
  logic [31:0]        start_count;

  mix_result_t expected_q [$];
  int          errors = 0;
  int          send_idle = 35;
  int          recv_idle = 67;
  longint      cycles = 0;
  bit          pending_clear = 1'b0;
  logic [3:0]  clear_slot;

  function automatic logic signed [23:0] clip24(longint v);
    if (v > 8388607) return 24'sh7FFFFF;
    if (v < -8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  function automatic mix_result_t voice_engine_step(svm_pkg::req_t r);
    mix_result_t o;
    longint lacc, racc;
    int pick;
    logic [31:0] age, best_age;
    logic [15:0] a;
    o.left = '0;
    o.right = '0;
    o.status = svm_pkg::STAT_DONE;
    case (r.op)
      svm_pkg::CMD_WRITE: begin
        sample_mem[r.address] = r.sample_value;
        word_written[r.address] = 1'b1;
      end
      svm_pkg::CMD_DEFINE: begin
        slot_base[r.slot] = r.address;
        slot_len[r.slot] = (r.length > 17'd65536) ? 17'd65536 : r.length;
      end
      svm_pkg::CMD_MAP: begin
        if (!r.map_valid) note_mapped[r.note] = 1'b0;
        else begin
          note_mapped[r.note] = 1'b1;
          note_slot[r.note] = r.slot;
        end
      end
      svm_pkg::CMD_ON: begin
        if (!note_mapped[r.note] || slot_len[note_slot[r.note]] == 0) begin
          o.status = svm_pkg::STAT_IGNORED;
        end else begin
          pick = -1;
          for (int i = 0; i < svm_pkg::MAX_VOICES; i++)
            if (!voice_on[i] && pick < 0) pick = i;
          if (pick < 0) o.status = svm_pkg::STAT_DROPPED;
          else begin
            voice_on[pick] = 1'b1;
            voice_slot[pick] = note_slot[r.note];
            voice_pos[pick] = '0;
            voice_stamp[pick] = start_count;
            start_count++;
          end
        end
      end
      svm_pkg::CMD_OFF: begin
        if (!note_mapped[r.note]) o.status = svm_pkg::STAT_IGNORED;
        else begin
          pick = -1;
          best_age = '0;
          for (int i = 0; i < svm_pkg::MAX_VOICES; i++) begin
            age = start_count - voice_stamp[i];
            if (voice_on[i] && voice_slot[i] == note_slot[r.note] &&
                (pick < 0 || age < best_age)) begin
              pick = i;
              best_age = age;
            end
          end
          if (pick < 0) o.status = svm_pkg::STAT_IGNORED;
          else voice_on[pick] = 1'b0;
        end
      end
      svm_pkg::CMD_MIX: begin
        lacc = r.left_in;
        racc = r.right_in;
        for (int i = 0; i < svm_pkg::MAX_VOICES; i++) begin
          if (voice_on[i]) begin
            if (voice_pos[i] >= slot_len[voice_slot[i]]) voice_on[i] = 1'b0;
            else begin
              a = slot_base[voice_slot[i]] + voice_pos[i][15:0];
              lacc += longint'(sample_mem[a]) * 256;
              racc += longint'(sample_mem[a]) * 256;
              voice_pos[i]++;
              if (voice_pos[i] >= slot_len[voice_slot[i]]) voice_on[i] = 1'b0;
            end
          end
        end
        o.left = clip24(lacc);
        o.right = clip24(racc);
      end
      default: ;
    endcase
    o.voices = '0;
    for (int i = 0; i < svm_pkg::MAX_VOICES; i++) o.voices += voice_on[i];
    return o;
  endfunction

  function automatic svm_pkg::req_t mk(svm_pkg::command_t op, int note, int slot, int mv,
                                       int addr, int len, int sval, int lin, int rin);
    svm_pkg::req_t r;
    r.op = op;
    r.note = 7'(note);
    r.slot = 4'(slot);
    r.map_valid = 1'(mv);
    r.address = 16'(addr);
    r.length = 17'(len);
    r.sample_value = 16'(sval);
    r.left_in = 24'(lin);
    r.right_in = 24'(rin);
    return r;
  endfunction

  // shortens a slot so that playback only touches written words
  function automatic logic [16:0] covered_len(logic [15:0] base, logic [16:0] len);
    logic [16:0] n;
    n = '0;
    while (n < len && word_written[base + n[15:0]]) n++;
    return n;
  endfunction

  function automatic svm_pkg::req_t random_request();
    svm_pkg::req_t r;
    int pick;
    r = mk(svm_pkg::CMD_WRITE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom);
    if (pending_clear) begin
      r.op = svm_pkg::CMD_DEFINE;
      r.slot = clear_slot;
      r.length = '0;
      pending_clear = 1'b0;
      return r;
    end
    pick = $urandom_range(0, 99);
    if (pick < 28) begin
      r.op = svm_pkg::CMD_WRITE;
      if ($urandom_range(0, 9) != 0) r.address = 16'($urandom_range(0, 1023));
    end else if (pick < 38) begin
      r.op = svm_pkg::CMD_DEFINE;
      if ($urandom_range(0, 9) == 0) begin
        // oversized slot, emptied again before any mix can read it
        r.length = 17'($urandom_range(65536, 131071));
        pending_clear = 1'b1;
        clear_slot = r.slot;
      end else begin
        r.address = 16'($urandom_range(0, 1023));
        r.length = covered_len(r.address, 17'($urandom_range(0, 48)));
      end
    end else if (pick < 48) begin
      r.op = svm_pkg::CMD_MAP;
      if ($urandom_range(0, 3) != 0) r.note = 7'($urandom_range(0, 31));
      r.map_valid = ($urandom_range(0, 4) != 0);
    end else if (pick < 66) begin
      r.op = svm_pkg::CMD_ON;
      if ($urandom_range(0, 7) != 0) r.note = 7'($urandom_range(0, 31));
    end else if (pick < 76) begin
      r.op = svm_pkg::CMD_OFF;
      if ($urandom_range(0, 7) != 0) r.note = 7'($urandom_range(0, 31));
    end else if (pick < 98) begin
      r.op = svm_pkg::CMD_MIX;
    end else begin
      r.op = ($urandom_range(0, 1) != 0) ? svm_pkg::CMD_NOP6 : svm_pkg::CMD_NOP7;
    end
    return r;
  endfunction

  task automatic send_request(svm_pkg::req_t r, bit typed, mix_result_t want);
    mix_result_t p;
    while ($urandom_range(0, 99) < send_idle) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.command <= r.op;
    req_if.note <= r.note;
    req_if.slot <= r.slot;
    req_if.map_valid <= r.map_valid;
    req_if.address <= r.address;
    req_if.length <= r.length;
    req_if.sample_value <= r.sample_value;
    req_if.left_in <= r.left_in;
    req_if.right_in <= r.right_in;
    do @(negedge clk); while (!req_if.ready);
    @(posedge clk);
    p = voice_engine_step(r);
    expected_q = {expected_q, (typed ? want : p)};
  endtask

  always @(posedge clk) begin
    res_if.ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  always @(negedge clk) begin
    mix_result_t e;
    if (!rst && res_if.valid && res_if.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result l=%h r=%h st=%0d av=%0d", $time,
                 res_if.left_out, res_if.right_out, res_if.status, res_if.active_voices);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (res_if.left_out !== e.left || res_if.right_out !== e.right ||
            res_if.status !== e.status || res_if.active_voices !== e.voices) begin
          $display("%0t: mismatch expected l=%h r=%h st=%0d av=%0d actual l=%h r=%h st=%0d av=%0d",
                   $time, e.left, e.right, e.status, e.voices, res_if.left_out,
                   res_if.right_out, res_if.status, res_if.active_voices);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 3000000) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic mix_result_t res(int l, int r, svm_pkg::status_t st, int av);
    mix_result_t o;
    o.left = 24'(l);
    o.right = 24'(r);
    o.status = st;
    o.voices = 5'(av);
    return o;
  endfunction

  initial begin
    stim_row_t rows [$];
    mix_result_t none;
    none = res(0, 0, svm_pkg::STAT_DONE, 0);
    req_if.valid = 1'b0;
    req_if.command = '0;
    req_if.note = '0;
    req_if.slot = '0;
    req_if.map_valid = 1'b0;
    req_if.address = '0;
    req_if.length = '0;
    req_if.sample_value = '0;
    req_if.left_in = '0;
    req_if.right_in = '0;
    res_if.ready = 1'b0;
    for (int i = 0; i < svm_pkg::NUM_SLOTS; i++) begin
      slot_base[i] = '0;
      slot_len[i] = '0;
    end
    for (int i = 0; i < svm_pkg::NUM_NOTES; i++) note_mapped[i] = 1'b0;
    for (int i = 0; i < svm_pkg::MAX_VOICES; i++) voice_on[i] = 1'b0;
    start_count = '0;

    rows = '{
      '{mk(svm_pkg::CMD_MIX, 0, 0, 0, 0, 0, 0, 24'h7FFFFF, 24'h800000), 1, 1,
        res(24'h7FFFFF, 24'h800000, svm_pkg::STAT_DONE, 0)},
      '{mk(svm_pkg::CMD_ON, 5, 0, 0, 0, 0, 0, 0, 0), 1, 1,
        res(0, 0, svm_pkg::STAT_IGNORED, 0)},
      '{mk(svm_pkg::CMD_OFF, 127, 0, 0, 0, 0, 0, 0, 0), 1, 1,
        res(0, 0, svm_pkg::STAT_IGNORED, 0)},
      '{mk(svm_pkg::CMD_WRITE, 0, 0, 0, 65535, 0, 16'h7FFF, 0, 0), 1, 1, none},
      '{mk(svm_pkg::CMD_WRITE, 0, 0, 0, 0, 0, 16'h8000, 0, 0), 1, 1, none},
      '{mk(svm_pkg::CMD_WRITE, 0, 0, 0, 1, 0, 16'h1234, 0, 0), 1, 1, none},
      '{mk(svm_pkg::CMD_DEFINE, 0, 0, 0, 65535, 3, 0, 0, 0), 1, 1, none},
      '{mk(svm_pkg::CMD_DEFINE, 0, 15, 0, 0, 0, 0, 0, 0), 1, 1, none},
      '{mk(svm_pkg::CMD_MAP, 127, 15, 1, 0, 0, 0, 0, 0), 1, 1, none},
      '{mk(svm_pkg::CMD_ON, 127, 0, 0, 0, 0, 0, 0, 0), 1, 1,
        res(0, 0, svm_pkg::STAT_IGNORED, 0)},
      '{mk(svm_pkg::CMD_MAP, 0, 0, 1, 0, 0, 0, 0, 0), 1, 1, none},
      '{mk(svm_pkg::CMD_ON, 0, 0, 0, 0, 0, 0, 0, 0), 16, 0, none},
      '{mk(svm_pkg::CMD_ON, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1,
        res(0, 0, svm_pkg::STAT_DROPPED, 16)},
      '{mk(svm_pkg::CMD_MIX, 0, 0, 0, 0, 0, 0, 24'h7FFFFF, 24'h000000), 1, 1,
        res(24'h7FFFFF, 24'h7FFFFF, svm_pkg::STAT_DONE, 16)},
      '{mk(svm_pkg::CMD_MIX, 0, 0, 0, 0, 0, 0, 24'h800000, 24'h800000), 1, 1,
        res(24'h800000, 24'h800000, svm_pkg::STAT_DONE, 16)},
      '{mk(svm_pkg::CMD_OFF, 0, 0, 0, 0, 0, 0, 0, 0), 16, 0, none},
      '{mk(svm_pkg::CMD_OFF, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1,
        res(0, 0, svm_pkg::STAT_IGNORED, 0)},
      '{mk(svm_pkg::CMD_ON, 0, 0, 0, 0, 0, 0, 0, 0), 2, 0, none},
      '{mk(svm_pkg::CMD_DEFINE, 0, 0, 0, 0, 1, 0, 0, 0), 1, 0, none},
      '{mk(svm_pkg::CMD_MIX, 0, 0, 0, 0, 0, 0, 24'h000100, 24'hFFFF00), 2, 0, none},
      '{mk(svm_pkg::CMD_MAP, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1, none},
      '{mk(svm_pkg::CMD_ON, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1,
        res(0, 0, svm_pkg::STAT_IGNORED, 0)},
      '{mk(svm_pkg::CMD_NOP6, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1, none},
      '{mk(svm_pkg::CMD_NOP7, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1, none}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i])
      for (int k = 0; k < rows[i].reps; k++) send_request(rows[i].cmd, rows[i].typed, rows[i].want);

    for (int n = 0; n < 1000; n++) begin
      if (n == 333) begin
        send_idle = 67;
        recv_idle = 35;
      end else if (n == 666) begin
        send_idle = 0;
        recv_idle = 0;
      end
      send_request(random_request(), 1'b0, none);
    end
    if (pending_clear) send_request(random_request(), 1'b0, none);
    req_if.valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
